// ----- hw/rtl/spvi_pkg.sv -----
// shared types, widths and constants for the variable-integral speed pid
package spvi_pkg;

    // data path widths
    localparam int DATA_WIDTH = 16;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int OPA_W      = DATA_WIDTH + 1;        // signed multiplicand
    localparam int OPB_W      = GAIN_W + 1;            // unsigned multiplier
    localparam int PROD_W     = OPA_W + OPB_W + 1;     // signed product
    localparam int ACC_W      = PROD_W + 1;
    localparam int FRAC_SHIFT = 12;
    localparam int Y_W        = ACC_W - FRAC_SHIFT;
    localparam int INT_W      = DATA_WIDTH + 2;        // integral sum before clamp

    // divisor and coefficient
    localparam int DEN_W       = 33;
    localparam int Q_W         = 17;
    localparam int C_NUM_SHIFT = 36;
    localparam int INC_SHIFT   = 16;
    localparam logic [DEN_W-1:0] DEN_ONE      = DEN_W'(1) << 20;
    localparam logic [DEN_W-1:0] DIV_REM_INIT = DEN_W'(1) << (C_NUM_SHIFT - Q_W);

    // step counters
    localparam int MUL_STEPS = OPB_W;
    localparam int DIV_STEPS = Q_W;
    localparam int CNT_W     = 5;

    // error saturation bounds
    localparam logic signed [DATA_WIDTH-1:0] E_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] E_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LIMIT = 3'd5;

    // reset values
    localparam logic [GAIN_W-1:0] KP_RESET        = 16'd2458;
    localparam logic [GAIN_W-1:0] KI_RESET        = 16'd82;
    localparam logic [GAIN_W-1:0] KD_RESET        = 16'd410;
    localparam logic [GAIN_W-1:0] SLOPE_RESET     = 16'd819;
    localparam logic [LIM_W-1:0]  INT_LIMIT_RESET = 15'd2560;
    localparam logic [LIM_W-1:0]  OUT_LIMIT_RESET = 15'd6400;

    typedef struct packed {
        logic                     start;
        logic signed [OPA_W-1:0]  mcand;
        logic        [OPB_W-1:0]  mplier;
    } t_mul_req;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [PROD_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic           busy;
        logic           done;
        logic [Q_W-1:0] quot;
    } t_div_rsp;

endpackage

// ----- hw/rtl/spvi_mul.sv -----
// bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
module spvi_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spvi_pkg::t_mul_req  i_req,
    output spvi_pkg::t_mul_rsp  o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [spvi_pkg::CNT_W-1:0]         r_cnt;
    logic signed [spvi_pkg::OPA_W-1:0]  r_mcand;
    logic signed [spvi_pkg::OPA_W:0]    r_hi;
    logic [spvi_pkg::OPB_W-1:0]         r_lo;

    logic signed [spvi_pkg::OPA_W:0]    addend;
    logic signed [spvi_pkg::OPA_W:0]    sum;

    // add the multiplicand when the current multiplier bit is set
    assign addend = r_lo[0] ? {r_mcand[spvi_pkg::OPA_W-1], r_mcand} : '0;
    assign sum    = r_hi + addend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= spvi_pkg::CNT_W'(spvi_pkg::MUL_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - spvi_pkg::CNT_W'(1);
                if (r_cnt == spvi_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial product shifts right one bit per step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.mcand;
            r_hi    <= '0;
            r_lo    <= i_req.mplier;
        end else if (r_busy) begin
            r_hi <= {sum[spvi_pkg::OPA_W], sum[spvi_pkg::OPA_W:1]};
            r_lo <= {sum[0], r_lo[spvi_pkg::OPB_W-1:1]};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.prod = {r_hi, r_lo};

endmodule

// ----- hw/rtl/spvi_div.sv -----
// restoring divider, one quotient bit per cycle, fixed dividend 2^36
module spvi_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  spvi_pkg::t_div_req  i_req,
    output spvi_pkg::t_div_rsp  o_rsp
);

    logic                           r_busy;
    logic                           r_done;
    logic [spvi_pkg::CNT_W-1:0]     r_cnt;
    logic [spvi_pkg::DEN_W-1:0]     r_den;
    logic [spvi_pkg::DEN_W-1:0]     r_rem;
    logic [spvi_pkg::Q_W-1:0]       r_quot;

    logic [spvi_pkg::DEN_W:0]       trial;
    logic [spvi_pkg::DEN_W+1:0]     diff;
    logic                           fits;

    // dividend below the quotient window is all zero, so shift in zeros
    assign trial = {r_rem, 1'b0};
    assign diff  = {1'b0, trial} - {2'b00, r_den};
    assign fits  = ~diff[spvi_pkg::DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= spvi_pkg::CNT_W'(spvi_pkg::DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - spvi_pkg::CNT_W'(1);
                if (r_cnt == spvi_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_den  <= i_req.den;
            r_rem  <= spvi_pkg::DIV_REM_INIT;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[spvi_pkg::DEN_W-1:0] : trial[spvi_pkg::DEN_W-1:0];
            r_quot <= {r_quot[spvi_pkg::Q_W-2:0], fits};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

// ----- hw/rtl/speed_pid_variable_integral.sv -----
// speed pid controller with variable-speed integration, top level
//
// one transfer on the s_axis channel is one control tick: setpoint and measured
// speed in signed q8.8. the block answers each tick with exactly one transfer on
// m_axis: the clamped drive value and a flag set when the output limit applied.
// gains, integral slope and the two limits are written over the cfg channel
// (index, data), which is always ready; write them only while no tick is open.
// a tick makes six passes through the bit-serial units: slope * |e|, the
// 17-step divide for the coefficient, |e| * c, then kp, ki and kd products,
// each with 17 shift steps, and then loads the output register. one tick is
// worked at a time, so a new tick is not taken until the last one is through;
// input ready returns as the result loads. the result sits in an output
// register, so the next tick is taken while the previous result still waits;
// a stalled receiver only holds the last step until the register frees up.
// reset (synchronous, active low) restores the register defaults and clears
// the integral and the stored last error.
module speed_pid_variable_integral (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] setpoint, [31:16] measured
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] drive
    output logic        m_axis_tuser,   // [0] clamped
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int DW = spvi_pkg::DATA_WIDTH;

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DEN  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_INC  = 3'd3;
    localparam logic [2:0] ST_KP   = 3'd4;
    localparam logic [2:0] ST_KI   = 3'd5;
    localparam logic [2:0] ST_KD   = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    // configuration registers
    logic [spvi_pkg::GAIN_W-1:0] r_kp;
    logic [spvi_pkg::GAIN_W-1:0] r_ki;
    logic [spvi_pkg::GAIN_W-1:0] r_kd;
    logic [spvi_pkg::GAIN_W-1:0] r_slope;
    logic [spvi_pkg::LIM_W-1:0]  r_int_lim;
    logic [spvi_pkg::LIM_W-1:0]  r_out_lim;

    // control
    logic [2:0] r_state;
    logic       r_go;
    logic       r_mvalid;

    // controller state and per-tick working values
    logic signed [DW-1:0]                r_last;
    logic signed [DW-1:0]                r_integ;
    logic signed [DW-1:0]                r_err;
    logic        [DW-1:0]                r_mag;
    logic signed [DW:0]                  r_de;
    logic        [spvi_pkg::DEN_W-1:0]   r_den;
    logic        [spvi_pkg::Q_W-1:0]     r_c;
    logic signed [spvi_pkg::ACC_W-1:0]   r_acc;
    logic signed [DW-1:0]                r_drive;
    logic                                r_clamped;

    spvi_pkg::t_mul_req mul_req;
    spvi_pkg::t_mul_rsp mul_rsp;
    spvi_pkg::t_div_req div_req;
    spvi_pkg::t_div_rsp div_rsp;

    logic                               in_xfer;
    logic                               out_free;
    logic signed [DW-1:0]               in_sp;
    logic signed [DW-1:0]               in_ms;
    logic signed [DW:0]                 diff;
    logic signed [DW-1:0]               e_sat;
    logic signed [DW:0]                 e_neg;
    logic signed [DW:0]                 de;
    logic        [spvi_pkg::Q_W-1:0]    inc_mag;
    logic signed [spvi_pkg::INT_W-1:0]  isum;
    logic signed [spvi_pkg::INT_W-1:0]  ilim;
    logic signed [DW-1:0]               n_integ;
    logic signed [spvi_pkg::ACC_W-1:0]  prod_ext;
    logic signed [spvi_pkg::Y_W-1:0]    y;
    logic signed [spvi_pkg::Y_W-1:0]    olim;
    logic signed [spvi_pkg::Y_W-1:0]    n_drive_y;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_mvalid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;

    // error, saturated to the data width
    assign in_sp = $signed(s_axis_tdata[15:0]);
    assign in_ms = $signed(s_axis_tdata[31:16]);
    assign diff  = {in_sp[DW-1], in_sp} - {in_ms[DW-1], in_ms};
    always_comb begin
        if (diff[DW] != diff[DW-1]) begin
            e_sat = diff[DW] ? spvi_pkg::E_MIN : spvi_pkg::E_MAX;
        end else begin
            e_sat = diff[DW-1:0];
        end
    end
    assign e_neg = -{e_sat[DW-1], e_sat};
    assign de    = {e_sat[DW-1], e_sat} - {r_last[DW-1], r_last};

    // operand selection for the shared multiplier
    always_comb begin
        mul_req.start = r_go && (r_state == ST_DEN || r_state == ST_INC ||
                                 r_state == ST_KP || r_state == ST_KI || r_state == ST_KD);
        case (r_state)
            ST_INC: begin
                mul_req.mcand  = {1'b0, r_mag};
                mul_req.mplier = r_c;
            end
            ST_KP: begin
                mul_req.mcand  = {r_err[DW-1], r_err};
                mul_req.mplier = {1'b0, r_kp};
            end
            ST_KI: begin
                mul_req.mcand  = {r_integ[DW-1], r_integ};
                mul_req.mplier = {1'b0, r_ki};
            end
            ST_KD: begin
                mul_req.mcand  = r_de;
                mul_req.mplier = {1'b0, r_kd};
            end
            default: begin
                mul_req.mcand  = {1'b0, r_mag};
                mul_req.mplier = {1'b0, r_slope};
            end
        endcase
    end

    assign div_req.start = r_go && (r_state == ST_DIV);
    assign div_req.den   = r_den;

    spvi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    spvi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // integral step: add the scaled error with the sign of the error, then clamp
    assign inc_mag = mul_rsp.prod[spvi_pkg::INC_SHIFT +: spvi_pkg::Q_W];
    assign ilim    = {3'b000, r_int_lim};
    always_comb begin
        if (r_err[DW-1]) begin
            isum = {{2{r_integ[DW-1]}}, r_integ} - {1'b0, inc_mag};
        end else begin
            isum = {{2{r_integ[DW-1]}}, r_integ} + {1'b0, inc_mag};
        end
        if (isum > ilim) begin
            n_integ = ilim[DW-1:0];
        end else if (isum < -ilim) begin
            n_integ = DW'(-ilim);
        end else begin
            n_integ = isum[DW-1:0];
        end
    end

    assign prod_ext = {mul_rsp.prod[spvi_pkg::PROD_W-1], mul_rsp.prod};

    // floor shift of the accumulator, then the symmetric output clamp
    assign y    = r_acc[spvi_pkg::ACC_W-1:spvi_pkg::FRAC_SHIFT];
    assign olim = {{(spvi_pkg::Y_W-spvi_pkg::LIM_W){1'b0}}, r_out_lim};
    always_comb begin
        if (y > olim) begin
            n_drive_y = olim;
        end else if (y < -olim) begin
            n_drive_y = -olim;
        end else begin
            n_drive_y = y;
        end
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp      <= spvi_pkg::KP_RESET;
            r_ki      <= spvi_pkg::KI_RESET;
            r_kd      <= spvi_pkg::KD_RESET;
            r_slope   <= spvi_pkg::SLOPE_RESET;
            r_int_lim <= spvi_pkg::INT_LIMIT_RESET;
            r_out_lim <= spvi_pkg::OUT_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spvi_pkg::REG_KP:        r_kp      <= i_cfg_data;
                spvi_pkg::REG_KI:        r_ki      <= i_cfg_data;
                spvi_pkg::REG_KD:        r_kd      <= i_cfg_data;
                spvi_pkg::REG_SLOPE:     r_slope   <= i_cfg_data;
                spvi_pkg::REG_INT_LIMIT: r_int_lim <= i_cfg_data[spvi_pkg::LIM_W-1:0];
                spvi_pkg::REG_OUT_LIMIT: r_out_lim <= i_cfg_data[spvi_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_go     <= 1'b0;
            r_mvalid <= 1'b0;
            r_last   <= '0;
            r_integ  <= '0;
        end else begin
            r_go <= 1'b0;
            if (r_mvalid && m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_state <= ST_DEN;
                        r_go    <= 1'b1;
                    end
                end
                ST_DEN: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_DIV;
                        r_go    <= 1'b1;
                    end
                end
                ST_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= ST_INC;
                        r_go    <= 1'b1;
                    end
                end
                ST_INC: begin
                    if (mul_rsp.done) begin
                        r_integ <= n_integ;
                        r_state <= ST_KP;
                        r_go    <= 1'b1;
                    end
                end
                ST_KP: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_KI;
                        r_go    <= 1'b1;
                    end
                end
                ST_KI: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_KD;
                        r_go    <= 1'b1;
                    end
                end
                ST_KD: begin
                    if (mul_rsp.done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // wait here while the receiver still holds the previous result
                    if (out_free) begin
                        r_mvalid <= 1'b1;
                        r_last   <= r_err;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // per-tick data path registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_err <= e_sat;
            r_mag <= e_sat[DW-1] ? e_neg[DW-1:0] : e_sat;
            r_de  <= de;
        end
        if (r_state == ST_DEN && mul_rsp.done) begin
            r_den <= mul_rsp.prod[spvi_pkg::DEN_W-1:0] + spvi_pkg::DEN_ONE;
        end
        if (r_state == ST_DIV && div_rsp.done) begin
            r_c <= div_rsp.quot;
        end
        if (r_state == ST_KP && mul_rsp.done) begin
            r_acc <= prod_ext;
        end
        if ((r_state == ST_KI || r_state == ST_KD) && mul_rsp.done) begin
            r_acc <= r_acc + prod_ext;
        end
        if (r_state == ST_OUT && out_free) begin
            r_drive   <= n_drive_y[DW-1:0];
            r_clamped <= (n_drive_y != y);
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_drive;
    assign m_axis_tuser  = r_clamped;

    // the multiplier and the divider never run at once
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mul_rsp.busy && div_rsp.busy))
        else $error("multiplier and divider busy together");

    // a product only completes in a state that launched one
    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_rsp.done |-> (r_state == ST_DEN || r_state == ST_INC || r_state == ST_KP ||
                          r_state == ST_KI || r_state == ST_KD))
        else $error("multiplier done outside a multiply step");

    // a clamped result sits exactly on one of the output limits
    a_clamp_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
            ($signed(m_axis_tdata) == $signed({1'b0, r_out_lim}) ||
             $signed(m_axis_tdata) == -$signed({1'b0, r_out_lim})))
        else $error("clamped result not at the output limit");

    // the sequencer only leaves idle on an accepted tick
    a_start_on_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && !in_xfer) |=> (r_state == ST_IDLE))
        else $error("sequencer left idle without an input transfer");

endmodule

// ----- dv/tb_speed_pid_variable_integral.sv -----
// testbench for the variable-integral speed pid: directed, random and back-pressure tests
`timescale 1ns / 100ps

module tb_speed_pid_variable_integral;

    // indexes past the register map, writes there must change nothing
    localparam logic [spvi_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [spvi_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // watchdog bound on the whole run; it is several times the slowest legal
    // run, idle gaps and stalls included
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int          RANDOM_PHASES     = 14;
    localparam int          TICKS_PER_PHASE   = 100;
    localparam int          SETTLE_CYCLES     = 150;

    typedef struct packed {
        logic signed [spvi_pkg::DATA_WIDTH-1:0] drive;
        logic                                   clamped;
    } t_drive_result;

    // dut connections, all inputs known from time zero
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;

    // controller settings and state as the block should hold them
    logic [spvi_pkg::GAIN_W-1:0]            kp_setting;
    logic [spvi_pkg::GAIN_W-1:0]            ki_setting;
    logic [spvi_pkg::GAIN_W-1:0]            kd_setting;
    logic [spvi_pkg::GAIN_W-1:0]            slope_setting;
    logic [spvi_pkg::LIM_W-1:0]             int_limit_setting;
    logic [spvi_pkg::LIM_W-1:0]             out_limit_setting;
    logic signed [spvi_pkg::DATA_WIDTH-1:0] prev_error;
    logic signed [spvi_pkg::DATA_WIDTH-1:0] integral_acc;

    // drive values still owed by the block, oldest first
    t_drive_result expected_drive_q[$];

    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;

    // idling controls, written only by the test sequence
    bit          src_idle_on  = 1'b0;
    bit          sink_idle_on = 1'b0;
    int unsigned hold_seq     = 0;
    int unsigned hold_len     = 0;

    // last tick sent, used to build runs of near-constant error
    logic signed [15:0] last_setpoint = '0;
    logic signed [15:0] last_measured = '0;

    speed_pid_variable_integral u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [15:0] setpoint, [31:16] measured
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [15:0] drive
        .m_axis_tuser  (m_axis_tuser),    // [0] clamped
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL speed_pid_variable_integral");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // one control tick: error, variable integral gain, pid sum, output clamp
    function automatic t_drive_result predict_drive(logic signed [15:0] setpoint,
                                                    logic signed [15:0] measured);
        longint        err;
        longint        mag;
        longint        den;
        longint        coef;
        longint        step;
        longint        sum;
        longint        y;
        longint        d;
        t_drive_result r;
        err = longint'(setpoint) - longint'(measured);
        // error saturates to the signed data range
        if (err > longint'(spvi_pkg::E_MAX)) err = longint'(spvi_pkg::E_MAX);
        if (err < longint'(spvi_pkg::E_MIN)) err = longint'(spvi_pkg::E_MIN);
        mag = (err < 0) ? -err : err;
        // coefficient 1/(slope*|e|*2^-20 + 1) in 2^-16 units, floored
        den  = longint'(slope_setting) * mag + (longint'(1) <<< 20);
        coef = (longint'(1) <<< 36) / den;
        step = (mag * coef) >>> 16;
        if (err < 0) step = -step;
        integral_acc = spvi_pkg::DATA_WIDTH'(clamp_to(longint'(integral_acc) + step,
                                                      longint'(int_limit_setting)));
        sum = longint'(kp_setting) * err
            + longint'(ki_setting) * longint'(integral_acc)
            + longint'(kd_setting) * (err - longint'(prev_error));
        // arithmetic shift floors toward minus infinity
        y = sum >>> spvi_pkg::FRAC_SHIFT;
        d = clamp_to(y, longint'(out_limit_setting));
        prev_error = spvi_pkg::DATA_WIDTH'(err);
        r.drive    = spvi_pkg::DATA_WIDTH'(d);
        r.clamped  = (d != y);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // idling
    // ------------------------------------------------------------------

    // mostly no gap or a short one, now and then a long one
    function automatic int unsigned pick_idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 20);
        return $urandom_range(40, 200);
    endfunction

    // receiver: random stalls, plus a long hold-off on request from a test
    initial begin
        int unsigned seen_seq;
        int unsigned stall_left;
        seen_seq   = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_seq != seen_seq) begin
                seen_seq   = hold_seq;
                stall_left = hold_len;
            end else if (stall_left == 0 && sink_idle_on && $urandom_range(0, 2) == 0) begin
                stall_left = pick_idle_len();
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_drive_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_drive_q.size() == 0) begin
                $display("%0t: unexpected drive transfer, actual drive %0d clamped %0b",
                         $time, $signed(m_axis_tdata), m_axis_tuser);
                fail_count++;
            end else begin
                exp_r = expected_drive_q.pop_front();
                if (m_axis_tdata !== exp_r.drive) begin
                    $display("%0t: drive mismatch, expected %0d actual %0d",
                             $time, exp_r.drive, $signed(m_axis_tdata));
                    fail_count++;
                end
                if (m_axis_tuser !== exp_r.clamped) begin
                    $display("%0t: clamped mismatch, expected %0b actual %0b",
                             $time, exp_r.clamped, m_axis_tuser);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offers one tick, optionally after an idle gap, and logs its prediction
    // on the accepting edge; valid stays high so the next call can follow
    // back to back without a second assignment in the same step
    task automatic send_tick(input logic signed [15:0] setpoint,
                             input logic signed [15:0] measured);
        int unsigned gap;
        gap = src_idle_on ? pick_idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {measured, setpoint};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_drive_q.push_back(predict_drive(setpoint, measured));
        last_setpoint = setpoint;
        last_measured = measured;
    endtask

    // drops valid in the step of the last transfer, then waits for every drive
    task automatic wait_all_drives();
        s_axis_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input logic [spvi_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            spvi_pkg::REG_KP:        kp_setting        = value;
            spvi_pkg::REG_KI:        ki_setting        = value;
            spvi_pkg::REG_KD:        kd_setting        = value;
            spvi_pkg::REG_SLOPE:     slope_setting     = value;
            spvi_pkg::REG_INT_LIMIT: int_limit_setting = value[spvi_pkg::LIM_W-1:0];
            spvi_pkg::REG_OUT_LIMIT: out_limit_setting = value[spvi_pkg::LIM_W-1:0];
            default: ;     // unmapped index is dropped
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_defaults();
        write_reg(spvi_pkg::REG_KP,        spvi_pkg::KP_RESET);
        write_reg(spvi_pkg::REG_KI,        spvi_pkg::KI_RESET);
        write_reg(spvi_pkg::REG_KD,        spvi_pkg::KD_RESET);
        write_reg(spvi_pkg::REG_SLOPE,     spvi_pkg::SLOPE_RESET);
        write_reg(spvi_pkg::REG_INT_LIMIT, 16'(spvi_pkg::INT_LIMIT_RESET));
        write_reg(spvi_pkg::REG_OUT_LIMIT, 16'(spvi_pkg::OUT_LIMIT_RESET));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // block must come out of reset with the default gains and limits
    task automatic test_reset_defaults();
        send_tick(16'sd0,     16'sd0);
        send_tick(16'sd256,   16'sd0);
        send_tick(16'sd0,     16'sd256);
        send_tick(16'sd1280, -16'sd1280);
        wait_all_drives();
    endtask

    // differences past the 16 bit range saturate, equal inputs give zero error
    task automatic test_error_saturation();
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sh8000, 16'sh8000);
        send_tick(16'sh7FFF, 16'sh7FFF);
        send_tick(16'sd1,    16'sd0);
        send_tick(16'sd0,    16'sd1);
        wait_all_drives();
    endtask

    // zero slope means the full error is integrated
    task automatic test_zero_slope();
        write_reg(spvi_pkg::REG_SLOPE, 16'd0);
        send_tick(16'sd3000,   16'sd0);
        send_tick(-16'sd3000,  16'sd0);
        send_tick(16'sd12000, -16'sd500);
        wait_all_drives();
    endtask

    // zero limits pin the integral and the drive to zero
    task automatic test_zero_limits();
        write_reg(spvi_pkg::REG_INT_LIMIT, 16'd0);
        write_reg(spvi_pkg::REG_OUT_LIMIT, 16'd0);
        send_tick(16'sd500,     16'sd0);
        send_tick(-16'sd500,    16'sd0);
        send_tick(16'sd0,       16'sd0);
        send_tick(16'sd20000,  -16'sd20000);
        wait_all_drives();
    endtask

    // full-scale gains and limits; bit 15 of a limit write is dropped and the
    // spare indexes must not disturb anything
    task automatic test_max_settings();
        write_reg(spvi_pkg::REG_KP,        16'hFFFF);
        write_reg(spvi_pkg::REG_KI,        16'hFFFF);
        write_reg(spvi_pkg::REG_KD,        16'hFFFF);
        write_reg(spvi_pkg::REG_SLOPE,     16'hFFFF);
        write_reg(spvi_pkg::REG_INT_LIMIT, 16'hFFFF);
        write_reg(spvi_pkg::REG_OUT_LIMIT, 16'hFFFF);
        write_reg(REG_SPARE_LO,            16'h0000);
        write_reg(REG_SPARE_HI,            16'h1234);
        send_tick(16'sh7FFF, 16'sh8000);
        send_tick(16'sh8000, 16'sh7FFF);
        send_tick(16'sd100,  16'sd0);
        send_tick(16'sd0,    16'sd0);
        wait_all_drives();
    endtask

    function automatic logic [15:0] pick_setting();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 4095));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] corner_value();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd0;
            3:       return 16'sd1;
            4:       return -16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly plausible loop traffic: measured close to setpoint or holding a
    // steady error so the integral walks toward its limit; the rest is noise and corners
    task automatic send_random_tick();
        logic signed [15:0] sp;
        logic signed [15:0] ms;
        int                 delta;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                sp    = 16'($urandom);
                delta = int'($urandom_range(0, 600)) - 300;
                ms    = sp + 16'(delta);
            end
            4, 5, 6: begin
                sp = 16'($urandom);
                ms = 16'($urandom);
            end
            7: begin
                sp = corner_value();
                ms = corner_value();
            end
            default: begin
                sp = last_setpoint + 16'(int'($urandom_range(0, 4)) - 2);
                ms = last_measured;
            end
        endcase
        send_tick(sp, ms);
    endtask

    // phases of random ticks, each under freshly written settings
    task automatic test_random_phases();
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            src_idle_on  = (ph % 3 != 1);
            sink_idle_on = (ph % 4 != 2);
            write_reg(spvi_pkg::REG_KP,        pick_setting());
            write_reg(spvi_pkg::REG_KI,        pick_setting());
            write_reg(spvi_pkg::REG_KD,        pick_setting());
            write_reg(spvi_pkg::REG_SLOPE,     pick_setting());
            write_reg(spvi_pkg::REG_INT_LIMIT, pick_setting());
            write_reg(spvi_pkg::REG_OUT_LIMIT, pick_setting());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
            repeat (TICKS_PER_PHASE) send_random_tick();
            wait_all_drives();
        end
    endtask

    // receiver holds off for a long stretch while ticks keep coming, so the
    // output register fills and the block must stall its input
    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        write_defaults();
        @(negedge i_clk);
        hold_len = 1000;
        hold_seq++;
        repeat (10) send_random_tick();
        wait_all_drives();
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        kp_setting        = spvi_pkg::KP_RESET;
        ki_setting        = spvi_pkg::KI_RESET;
        kd_setting        = spvi_pkg::KD_RESET;
        slope_setting     = spvi_pkg::SLOPE_RESET;
        int_limit_setting = spvi_pkg::INT_LIMIT_RESET;
        out_limit_setting = spvi_pkg::OUT_LIMIT_RESET;
        prev_error        = '0;
        integral_acc      = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_error_saturation();
        test_zero_slope();
        test_zero_limits();
        test_max_settings();
        test_random_phases();
        test_backpressure();

        // nothing more is owed; give a stray late transfer time to show up
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS speed_pid_variable_integral");
        end else begin
            $display("FAIL speed_pid_variable_integral");
        end
        $finish;
    end

endmodule
